/* rtl/segment_tree_range_add_mod_sum_macros.svh */
// Assertion macros for the segment tree range add / modulo / sum block.
// Used by segment_tree_range_add_mod_sum.sv; expects clk and rst_n in scope.
`ifndef SEGMENT_TREE_RANGE_ADD_MOD_SUM_MACROS_SVH
`define SEGMENT_TREE_RANGE_ADD_MOD_SUM_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define STRAM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define STRAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/stram_pkg.sv */
// Shared types and constants for the segment tree range add / modulo / sum block.
// No dependencies.
`timescale 1ns / 1ps

package stram_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int COUNT_W          = 11;
  localparam int DATA_W           = 64;
  localparam int RESET_COUNT      = 1024;

  // Operation codes of the input word
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_SET   = 2'd2,
    OP_MOD   = 2'd3
  } op_t;

  // One tree node as stored in the node memory
  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] max;
    logic [DATA_W-1:0] pend;
  } node_t;

endpackage

/* rtl/segment_tree_range_add_mod_sum.sv */
// Steps per word: the word is taken, each visited node is read, a full add writes the node, a lazy push writes
// both children and clears the tag, a pull-up merges both children, a leaf remainder runs a bit-serial divider.
// A range add or sum visits about four nodes per level, a modulo up to all leaves.
// Throughput: one word at a time; the next word is taken once the result is in the output register.
// Reset: synchronous, active low; a clearing pass writes all 4*MAX_ELEMENTS nodes to zero,
// one per cycle, before the first word is taken. element_count resets to 1024.
`timescale 1ns / 1ps
`include "segment_tree_range_add_mod_sum_macros.svh"

module segment_tree_range_add_mod_sum #(
  parameter int MAX_ELEMENTS = stram_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [stram_pkg::COUNT_W-1:0]       cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_opcode,
  input  logic [stram_pkg::COUNT_W-1:0]       in_range_left,
  input  logic [stram_pkg::COUNT_W-1:0]       in_range_right,
  input  logic [stram_pkg::COUNT_W-1:0]       in_position,
  input  logic signed [stram_pkg::DATA_W-1:0] in_operand_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [stram_pkg::DATA_W-1:0] out_range_sum,
  output logic                                out_is_query_result,
  output logic                                out_error
);

  localparam int IDX_BITS = $clog2(MAX_ELEMENTS + 1);
  localparam int CW       = (IDX_BITS > stram_pkg::COUNT_W) ? IDX_BITS : stram_pkg::COUNT_W;
  localparam int NODES    = 4 * MAX_ELEMENTS;
  localparam int NW       = $clog2(NODES);
  localparam int SD       = $clog2(MAX_ELEMENTS) + 1;
  localparam int SPW      = $clog2(SD + 1);
  localparam int SIW      = $clog2(SD);
  localparam int PW       = 32 + CW;
  localparam int DW       = stram_pkg::DATA_W;

  typedef enum logic [16:0] {
    S_CLEAR = 17'h00001,
    S_IDLE  = 17'h00002,
    S_ENTER = 17'h00004,
    S_NODE  = 17'h00008,
    S_ADDW  = 17'h00010,
    S_DIV   = 17'h00020,
    S_DIVW  = 17'h00040,
    S_PRD   = 17'h00080,
    S_PMUL  = 17'h00100,
    S_PWR   = 17'h00200,
    S_PK    = 17'h00400,
    S_DESC  = 17'h00800,
    S_RET   = 17'h01000,
    S_PLL   = 17'h02000,
    S_PLR   = 17'h04000,
    S_PLW   = 17'h08000,
    S_DONE  = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration and operation registers
  logic [stram_pkg::COUNT_W-1:0] cfg_cnt_r;
  stram_pkg::op_t                op_r;
  logic [CW-1:0]                 a_r, b_r, p_r;
  logic [DW-1:0]                 v_r;
  logic                          err_r;
  logic [DW-1:0]                 acc_r;

  // traversal registers
  logic [NW-1:0]  k_r;
  logic [CW-1:0]  l_r, r_r;
  logic [SPW-1:0] sp_r;
  logic [NW-1:0]  stk_k_r  [SD];
  logic [CW-1:0]  stk_l_r  [SD];
  logic [CW-1:0]  stk_r_r  [SD];
  logic           stk_ph_r [SD];
  logic           c_r;
  logic [NW-1:0]  clr_r;
  stram_pkg::node_t nd_r, cd_r;

  // multiplier and divider
  logic [PW-1:0]  plo_r;
  logic [31:0]    phi_r;
  logic [DW-1:0]  rem_r, dvd_r;
  logic           neg_r;
  logic [5:0]     dcnt_r;

  // output register
  logic           ov_r;
  logic [DW-1:0]  osum_r;
  logic           oq_r, oerr_r;

  // node memory
  stram_pkg::node_t node_mem [NODES];
  stram_pkg::node_t rd_r, wd;
  logic [NW-1:0]    ra, wa;
  logic             mem_we;

  // active element count
  logic [CW-1:0] n_act;
  always_comb begin
    if (cfg_cnt_r == '0) begin
      n_act = CW'(1);
    end else if (CW'(cfg_cnt_r) > CW'(MAX_ELEMENTS)) begin
      n_act = CW'(MAX_ELEMENTS);
    end else begin
      n_act = CW'(cfg_cnt_r);
    end
  end

  // input checks
  logic [CW-1:0] in_a, in_b, in_p;
  logic          range_ok, pos_ok, bad_in, in_acc;
  assign in_a     = CW'(in_range_left);
  assign in_b     = CW'(in_range_right);
  assign in_p     = CW'(in_position);
  assign range_ok = (in_a != '0) && (in_b <= n_act) && (in_a <= in_b);
  assign pos_ok   = (in_p != '0) && (in_p <= n_act);
  assign in_acc   = in_valid && !in_stall;
  always_comb begin
    case (stram_pkg::op_t'(in_opcode))
      stram_pkg::OP_ADD:   bad_in = !range_ok;
      stram_pkg::OP_QUERY: bad_in = !range_ok;
      stram_pkg::OP_SET:   bad_in = !pos_ok;
      stram_pkg::OP_MOD:   bad_in = !range_ok || in_operand_value[DW-1] ||
                                    (in_operand_value == '0);
      default:             bad_in = 1'b1;
    endcase
  end

  // node geometry
  logic [CW:0]   lr_sum;
  logic [CW-1:0] mid, len_full, len_l, len_r;
  logic          leaf, full, below, has_tag, go_left;
  logic [NW-1:0] child;
  assign lr_sum   = {1'b0, l_r} + {1'b0, r_r};
  assign mid      = lr_sum[CW:1];
  assign len_full = r_r - l_r + CW'(1);
  assign len_l    = mid - l_r + CW'(1);
  assign len_r    = r_r - mid;
  assign leaf     = (l_r == r_r);
  assign full     = (a_r <= l_r) && (r_r <= b_r);
  assign below    = $signed(rd_r.max) < $signed(v_r);
  assign has_tag  = (rd_r.pend != '0);
  assign go_left  = (op_r == stram_pkg::OP_SET) ? (p_r <= mid) : (a_r <= mid);
  assign child    = {k_r[NW-2:0], c_r};

  // top of the return stack
  logic [SIW-1:0] top_i;
  logic [CW:0]    f_sum;
  logic [CW-1:0]  f_mid;
  logic           ret_right;
  assign top_i     = SIW'(sp_r - 1'b1);
  assign f_sum     = {1'b0, stk_l_r[top_i]} + {1'b0, stk_r_r[top_i]};
  assign f_mid     = f_sum[CW:1];
  assign ret_right = !stk_ph_r[top_i] && (op_r != stram_pkg::OP_SET) && (b_r > f_mid);

  // multiplier operands: addend times span length, in two 32-bit halves
  logic [DW-1:0] mul_v, prod;
  logic [CW-1:0] mul_n;
  always_comb begin
    if (state_r == S_PMUL) begin
      mul_v = nd_r.pend;
      mul_n = c_r ? len_r : len_l;
    end else begin
      mul_v = v_r;
      mul_n = len_full;
    end
  end
  assign prod = {phi_r, 32'd0} + DW'(plo_r);

  // divider step and result
  logic [DW-1:0] div_shift, rem_res, rd_mag;
  assign div_shift = {rem_r[DW-2:0], dvd_r[DW-1]};
  assign rem_res   = neg_r ? (DW'(0) - rem_r) : rem_r;
  assign rd_mag    = rd_r.sum[DW-1] ? (DW'(0) - rd_r.sum) : rd_r.sum;

  // memory port control
  logic child_leaf;
  assign child_leaf = c_r ? ((mid + CW'(1)) == r_r) : (l_r == mid);
  always_comb begin
    ra     = k_r;
    wa     = k_r;
    wd     = '0;
    mem_we = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        wa     = clr_r;
      end
      S_NODE: begin
        if ((op_r == stram_pkg::OP_SET) && leaf) begin
          mem_we = 1'b1;
          wd     = '{sum: v_r, max: v_r, pend: '0};
        end
      end
      S_ADDW: begin
        mem_we  = 1'b1;
        wd.sum  = cd_r.sum + prod;
        wd.max  = cd_r.max + v_r;
        wd.pend = leaf ? cd_r.pend : (cd_r.pend + v_r);
      end
      S_DIVW: begin
        mem_we = 1'b1;
        wd     = '{sum: rem_res, max: rem_res, pend: '0};
      end
      S_PRD: ra = child;
      S_PWR: begin
        mem_we  = 1'b1;
        wa      = child;
        wd.sum  = cd_r.sum + prod;
        wd.max  = cd_r.max + nd_r.pend;
        wd.pend = child_leaf ? cd_r.pend : (cd_r.pend + nd_r.pend);
      end
      S_PK: begin
        mem_we = 1'b1;
        wd     = '{sum: nd_r.sum, max: nd_r.max, pend: '0};
      end
      S_PLL: ra = {k_r[NW-2:0], 1'b0};
      S_PLR: ra = {k_r[NW-2:0], 1'b1};
      S_PLW: begin
        mem_we  = 1'b1;
        wd.sum  = cd_r.sum + rd_r.sum;
        wd.max  = ($signed(cd_r.max) < $signed(rd_r.max)) ? rd_r.max : cd_r.max;
        wd.pend = '0;
      end
      default: ;
    endcase
  end

  // node memory with write-first forwarding
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[wa] <= wd;
    end
    if (mem_we && (wa == ra)) begin
      rd_r <= wd;
    end else begin
      rd_r <= node_mem[ra];
    end
  end

  // next state
  state_t desc_to;
  assign desc_to = has_tag ? S_PRD : S_DESC;
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == NW'(NODES - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_acc) state_nxt = bad_in ? S_DONE : S_ENTER;
      S_ENTER: state_nxt = S_NODE;
      S_NODE: begin
        case (op_r)
          stram_pkg::OP_QUERY: state_nxt = full ? S_RET : desc_to;
          stram_pkg::OP_ADD:   state_nxt = full ? S_ADDW : desc_to;
          stram_pkg::OP_MOD:   state_nxt = below ? S_RET : (leaf ? S_DIV : desc_to);
          stram_pkg::OP_SET:   state_nxt = leaf ? S_RET : desc_to;
          default:             state_nxt = S_RET;
        endcase
      end
      S_ADDW:  state_nxt = S_RET;
      S_DIV:   if (dcnt_r == '0) state_nxt = S_DIVW;
      S_DIVW:  state_nxt = S_RET;
      S_PRD:   state_nxt = S_PMUL;
      S_PMUL:  state_nxt = S_PWR;
      S_PWR:   state_nxt = c_r ? S_PK : S_PRD;
      S_PK:    state_nxt = S_DESC;
      S_DESC:  state_nxt = S_ENTER;
      S_RET: begin
        if (sp_r == '0) begin
          state_nxt = S_DONE;
        end else if (ret_right) begin
          state_nxt = S_ENTER;
        end else begin
          state_nxt = (op_r == stram_pkg::OP_QUERY) ? S_RET : S_PLL;
        end
      end
      S_PLL:   state_nxt = S_PLR;
      S_PLR:   state_nxt = S_PLW;
      S_PLW:   state_nxt = S_RET;
      S_DONE:  if (!ov_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      cfg_cnt_r <= stram_pkg::COUNT_W'(stram_pkg::RESET_COUNT);
      clr_r     <= '0;
      sp_r      <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cfg_cnt_r <= cfg_wr_data;
      end
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + NW'(1);
      end
      // push a frame when descending, pop when leaving a finished node
      if (state_r == S_IDLE) begin
        sp_r <= '0;
      end else if (state_r == S_DESC) begin
        sp_r <= sp_r + SPW'(1);
      end else if ((state_r == S_RET) && (sp_r != '0) && !ret_right) begin
        sp_r <= sp_r - SPW'(1);
      end
      // hold the result until taken
      if ((state_r == S_DONE) && (!ov_r || !out_stall)) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    plo_r <= PW'(mul_v[31:0]) * PW'(mul_n);
    phi_r <= mul_v[DW-1:32] * 32'(mul_n);
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r  <= stram_pkg::op_t'(in_opcode);
          a_r   <= in_a;
          b_r   <= in_b;
          p_r   <= in_p;
          v_r   <= in_operand_value;
          err_r <= bad_in;
          acc_r <= '0;
          k_r   <= NW'(1);
          l_r   <= CW'(1);
          r_r   <= n_act;
        end
      end
      S_NODE: begin
        nd_r   <= rd_r;
        cd_r   <= rd_r;
        c_r    <= 1'b0;
        dvd_r  <= rd_mag;
        neg_r  <= rd_r.sum[DW-1];
        rem_r  <= '0;
        dcnt_r <= 6'd63;
        if ((op_r == stram_pkg::OP_QUERY) && full) begin
          acc_r <= acc_r + rd_r.sum;
        end
      end
      S_DIV: begin
        rem_r  <= (div_shift >= v_r) ? (div_shift - v_r) : div_shift;
        dvd_r  <= {dvd_r[DW-2:0], 1'b0};
        dcnt_r <= dcnt_r - 6'd1;
      end
      S_PMUL: cd_r <= rd_r;
      S_PWR:  c_r  <= 1'b1;
      S_DESC: begin
        stk_k_r[sp_r[SIW-1:0]]  <= k_r;
        stk_l_r[sp_r[SIW-1:0]]  <= l_r;
        stk_r_r[sp_r[SIW-1:0]]  <= r_r;
        stk_ph_r[sp_r[SIW-1:0]] <= !go_left;
        if (go_left) begin
          k_r <= {k_r[NW-2:0], 1'b0};
          r_r <= mid;
        end else begin
          k_r <= {k_r[NW-2:0], 1'b1};
          l_r <= mid + CW'(1);
        end
      end
      S_RET: begin
        if (sp_r != '0) begin
          if (ret_right) begin
            stk_ph_r[top_i] <= 1'b1;
            k_r <= {stk_k_r[top_i][NW-2:0], 1'b1};
            l_r <= f_mid + CW'(1);
            r_r <= stk_r_r[top_i];
          end else begin
            k_r <= stk_k_r[top_i];
            l_r <= stk_l_r[top_i];
            r_r <= stk_r_r[top_i];
          end
        end
      end
      S_PLR: cd_r <= rd_r;
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          osum_r <= acc_r;
          oq_r   <= (op_r == stram_pkg::OP_QUERY);
          oerr_r <= err_r;
        end
      end
      default: ;
    endcase
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = ov_r;
  assign out_range_sum       = osum_r;
  assign out_is_query_result = oq_r;
  assign out_error           = oerr_r;

  `STRAM_ASSERT_NOW(a_stack_bound, state_r != S_CLEAR, sp_r <= SPW'(SD), "stack overflow")
  `STRAM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "took word twice")
  `STRAM_ASSERT_NOW(a_div_rem, state_r == S_DIV, rem_r < v_r, "remainder not below divisor")
  `STRAM_ASSERT_NOW(a_no_idle_write, state_r == S_IDLE || state_r == S_DONE, !mem_we, "stray write")
  `STRAM_ASSERT_NOW(a_out_from_done, $rose(out_valid), $past(state_r == S_DONE), "stray result")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for segment_tree_range_add_mod_sum: lazy range add, range sum,
// point set and range modulo words are checked against a behavioral tree in this file.
// Depends on stram_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int NODES       = 4 * stram_pkg::MAX_ELEMENTS_DEF;
  localparam int CYCLE_LIMIT = 3000000;

  typedef logic [stram_pkg::DATA_W-1:0] word_t;

  typedef struct packed {
    word_t sum;
    logic  is_query;
    logic  err;
  } tree_result_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_wr_en = 1'b0;
  logic [stram_pkg::COUNT_W-1:0]       cfg_wr_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [1:0]                          in_opcode = '0;
  logic [stram_pkg::COUNT_W-1:0]       in_range_left = '0;
  logic [stram_pkg::COUNT_W-1:0]       in_range_right = '0;
  logic [stram_pkg::COUNT_W-1:0]       in_position = '0;
  logic signed [stram_pkg::DATA_W-1:0] in_operand_value = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [stram_pkg::DATA_W-1:0] out_range_sum;
  logic                                out_is_query_result;
  logic                                out_error;

  // Shadow tree state and register
  logic [stram_pkg::COUNT_W-1:0] shadow_count;
  word_t              sh_sum  [NODES];
  word_t              sh_max  [NODES];
  word_t              sh_pend [NODES];

  tree_result_t pending_results[$];
  int  mismatches = 0;
  int  words_sent = 0;
  int  words_checked = 0;
  int  queries_seen = 0;
  int  errors_seen = 0;
  int  cycles = 0;
  bit  idling_on = 1'b1;
  bit  long_hold_req = 1'b0;
  int  hold_left = 0;
  int  burst_left = 0;

  segment_tree_range_add_mod_sum i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_range_left       (in_range_left),
    .in_range_right      (in_range_right),
    .in_position         (in_position),
    .in_operand_value    (in_operand_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_range_sum       (out_range_sum),
    .out_is_query_result (out_is_query_result),
    .out_error           (out_error)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- tree predictor
  function automatic int span_count();
    if (shadow_count == 0) return 1;
    if (shadow_count > stram_pkg::MAX_ELEMENTS_DEF) return stram_pkg::MAX_ELEMENTS_DEF;
    return shadow_count;
  endfunction

  function automatic bit signed_below(word_t a, word_t b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic void tag_node(int k, int l, int r, word_t v);
    word_t width;
    width = word_t'(r - l + 1);
    sh_sum[k] = sh_sum[k] + v * width;
    sh_max[k] = sh_max[k] + v;
    if (l != r) sh_pend[k] = sh_pend[k] + v;
  endfunction

  function automatic void spread_tag(int k, int l, int r);
    int mid;
    mid = (l + r) >> 1;
    if (sh_pend[k] != 0) begin
      tag_node(2 * k, l, mid, sh_pend[k]);
      tag_node(2 * k + 1, mid + 1, r, sh_pend[k]);
      sh_pend[k] = '0;
    end
  endfunction

  function automatic void pull_up(int k);
    sh_sum[k] = sh_sum[2 * k] + sh_sum[2 * k + 1];
    sh_max[k] = signed_below(sh_max[2 * k], sh_max[2 * k + 1]) ?
                sh_max[2 * k + 1] : sh_max[2 * k];
  endfunction

  function automatic void add_range(int k, int l, int r, int a, int b, word_t v);
    int mid;
    mid = (l + r) >> 1;
    if (b < l || r < a) return;
    if (a <= l && r <= b) begin
      tag_node(k, l, r, v);
      return;
    end
    spread_tag(k, l, r);
    if (a <= mid) add_range(2 * k, l, mid, a, b, v);
    if (b > mid) add_range(2 * k + 1, mid + 1, r, a, b, v);
    pull_up(k);
  endfunction

  // Truncated remainder: the sign follows the dividend
  function automatic word_t trunc_rem(word_t x, word_t m);
    word_t mag;
    if (x[stram_pkg::DATA_W-1]) begin
      mag = (-x) % m;
      return -mag;
    end
    return x % m;
  endfunction

  function automatic void mod_range(int k, int l, int r, int a, int b, word_t m);
    int mid;
    mid = (l + r) >> 1;
    if (b < l || r < a) return;
    if (signed_below(sh_max[k], m)) return;
    if (l == r) begin
      sh_sum[k]  = trunc_rem(sh_sum[k], m);
      sh_max[k]  = sh_sum[k];
      sh_pend[k] = '0;
      return;
    end
    spread_tag(k, l, r);
    if (a <= mid) mod_range(2 * k, l, mid, a, b, m);
    if (b > mid) mod_range(2 * k + 1, mid + 1, r, a, b, m);
    pull_up(k);
  endfunction

  function automatic void set_point(int k, int l, int r, int p, word_t v);
    int mid;
    mid = (l + r) >> 1;
    if (l == r) begin
      sh_sum[k]  = v;
      sh_max[k]  = v;
      sh_pend[k] = '0;
      return;
    end
    spread_tag(k, l, r);
    if (p <= mid) set_point(2 * k, l, mid, p, v);
    else set_point(2 * k + 1, mid + 1, r, p, v);
    pull_up(k);
  endfunction

  function automatic word_t sum_range(int k, int l, int r, int a, int b);
    int    mid;
    word_t acc;
    mid = (l + r) >> 1;
    acc = '0;
    if (b < l || r < a) return '0;
    if (a <= l && r <= b) return sh_sum[k];
    spread_tag(k, l, r);
    if (a <= mid) acc = acc + sum_range(2 * k, l, mid, a, b);
    if (b > mid) acc = acc + sum_range(2 * k + 1, mid + 1, r, a, b);
    return acc;
  endfunction

  function automatic tree_result_t apply_word(stram_pkg::op_t op, int a, int b, int p,
                                              word_t v);
    tree_result_t res;
    int           n;
    bit           range_ok;
    n = span_count();
    range_ok = (a >= 1 && b <= n && a <= b);
    res = '0;
    res.is_query = (op == stram_pkg::OP_QUERY);
    case (op)
      stram_pkg::OP_ADD: begin
        if (range_ok) add_range(1, 1, n, a, b, v);
        else res.err = 1'b1;
      end
      stram_pkg::OP_QUERY: begin
        if (range_ok) res.sum = sum_range(1, 1, n, a, b);
        else res.err = 1'b1;
      end
      stram_pkg::OP_SET: begin
        if (p >= 1 && p <= n) set_point(1, 1, n, p, v);
        else res.err = 1'b1;
      end
      default: begin
        if (range_ok && !v[stram_pkg::DATA_W-1] && v != 0) mod_range(1, 1, n, a, b, v);
        else res.err = 1'b1;
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic send_word(stram_pkg::op_t op, int a, int b, int p, word_t v);
    int gap;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_range_left    <= a[stram_pkg::COUNT_W-1:0];
    in_range_right   <= b[stram_pkg::COUNT_W-1:0];
    in_position      <= p[stram_pkg::COUNT_W-1:0];
    in_operand_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_word(op, a, b, p, v));
    words_sent++;
  endtask

  // Pause the sender until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_count(int value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[stram_pkg::COUNT_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_count = value[stram_pkg::COUNT_W-1:0];
    @(posedge clk);
  endtask

  function automatic word_t rand_value();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return word_t'($signed($urandom_range(0, 200)) - 100);
      2: return $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
      default: return word_t'($urandom_range(0, 100000));
    endcase
  endfunction

  function automatic word_t rand_divisor();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};           // often negative: bad divisor
      1: return '0;
      2: return {1'b0, $urandom, $urandom} >> 1;
      default: return word_t'($urandom_range(1, 1000));
    endcase
  endfunction

  // Mostly legal ranges inside the active span, some arbitrary 11-bit fields
  task automatic send_random(int max_width);
    int             n, a, b, p;
    stram_pkg::op_t op;
    word_t          v;
    n  = span_count();
    op = stram_pkg::op_t'($urandom_range(0, 3));
    a  = $urandom_range(1, n);
    b  = a + $urandom_range(0, max_width - 1);
    if (b > n) b = n;
    p  = $urandom_range(1, n);
    if ($urandom_range(0, 9) == 0) begin
      a = $urandom_range(0, 2047);
      b = $urandom_range(0, 2047);
      p = $urandom_range(0, 2047);
    end
    v = (op == stram_pkg::OP_MOD) ? rand_divisor() : rand_value();
    send_word(op, a, b, p, v);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    send_word(stram_pkg::OP_SET, 0, 0, 1, 64'h7FFF_FFFF_FFFF_FFFF);
    send_word(stram_pkg::OP_SET, 0, 0, 1024, 64'h8000_0000_0000_0000);
    send_word(stram_pkg::OP_SET, 0, 0, 512, 64'd1000);
    send_word(stram_pkg::OP_QUERY, 1, 1024, 0, '0);
    send_word(stram_pkg::OP_ADD, 1, 1024, 0, -64'sd1);
    send_word(stram_pkg::OP_QUERY, 1, 1024, 0, '0);
    send_word(stram_pkg::OP_QUERY, 1024, 1024, 0, '0);
    send_word(stram_pkg::OP_ADD, 500, 520, 0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_word(stram_pkg::OP_MOD, 510, 515, 0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_word(stram_pkg::OP_MOD, 1000, 1024, 0, 64'd7);    // negative leaf stays put
    send_word(stram_pkg::OP_MOD, 1, 16, 0, 64'd1);
    send_word(stram_pkg::OP_QUERY, 1, 1024, 0, '0);
    send_word(stram_pkg::OP_ADD, 0, 5, 0, 64'd3);          // left below one
    send_word(stram_pkg::OP_QUERY, 1, 1025, 0, '0);        // right past the count
    send_word(stram_pkg::OP_MOD, 9, 8, 0, 64'd3);          // left after right
    send_word(stram_pkg::OP_SET, 0, 0, 0, 64'd5);          // position zero
    send_word(stram_pkg::OP_SET, 2047, 2047, 2047, 64'd5); // position past the count
    send_word(stram_pkg::OP_MOD, 1, 10, 0, '0);            // zero divisor
    send_word(stram_pkg::OP_MOD, 1, 10, 0, 64'h8000_0000_0000_0000); // negative divisor
    send_word(stram_pkg::OP_QUERY, 500, 520, 0, '0);
  endtask

  // Register extremes: zero acts as one, large values clamp
  task automatic test_count_extremes();
    write_count(0);
    repeat (10) send_random(2);
    write_count(2047);
    repeat (10) send_random(16);
    write_count(1);
    repeat (10) send_random(1);
    write_count(2);
    repeat (10) send_random(2);
  endtask

  // Hold the result side long enough for the block to back up its input
  task automatic test_backpressure();
    write_count(64);
    long_hold_req = 1'b1;
    repeat (20) send_random(64);
    drain();
  endtask

  task automatic test_random(int phases, int per_phase);
    int n;
    for (int ph = 0; ph < phases; ph++) begin
      n = (ph % 8 == 7) ? 1024 : $urandom_range(2, 64);
      write_count(n);
      repeat (per_phase) send_random(n == 1024 ? 32 : n);
    end
  endtask

  task automatic test_no_idling();
    drain();
    idling_on = 1'b0;
    test_random(2, 60);
  endtask

  // ---------------------------------------------------------------- result check and stall
  always @(posedge clk) begin
    tree_result_t exp_res;
    bit           stall_next;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      words_checked++;
      if (out_is_query_result) queries_seen++;
      if (out_error) errors_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word sum=%0d q=%0b err=%0b", $time,
                 out_range_sum, out_is_query_result, out_error);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_range_sum !== exp_res.sum) begin
          mismatches++;
          $display("%0t: range_sum expected %0d actual %0d", $time,
                   $signed(exp_res.sum), out_range_sum);
        end
        if (out_is_query_result !== exp_res.is_query) begin
          mismatches++;
          $display("%0t: is_query_result expected %0b actual %0b", $time,
                   exp_res.is_query, out_is_query_result);
        end
        if (out_error !== exp_res.err) begin
          mismatches++;
          $display("%0t: error expected %0b actual %0b", $time, exp_res.err, out_error);
        end
      end
    end
    // Advance the receiver's stall pattern
    stall_next = 1'b0;
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      stall_next = 1'b1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(0, 11);
      stall_next = 1'b1;
    end
    out_stall <= stall_next;
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    shadow_count = stram_pkg::COUNT_W'(stram_pkg::RESET_COUNT);
    for (int k = 0; k < NODES; k++) begin
      sh_sum[k]  = '0;
      sh_max[k]  = '0;
      sh_pend[k] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_count_extremes();
    test_backpressure();
    test_random(16, 60);
    test_no_idling();
    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d words (%0d queries, %0d error words) over register settings 0..2047,",
             words_checked, queries_seen, errors_seen);
    $display("with random idling, a long result hold and a final stretch at full rate.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
